// File: sv/tstq_pkg.sv
package tstq_pkg;

  // Fixed field widths of the stream payloads.
  localparam int TIME_W = 48;
  localparam int VAL_W  = 32;
  localparam int FIDX_W = 11;
  localparam int SUM_W  = 48;
  localparam int STAT_W = 2;
  localparam int REQ_W  = 2;

  // Bit offsets inside the slave-side tdata.
  localparam int OFS_SAMPLE_TIME  = 0;
  localparam int OFS_SAMPLE_VALUE = OFS_SAMPLE_TIME + TIME_W;
  localparam int OFS_QUERY_START  = OFS_SAMPLE_VALUE + VAL_W;
  localparam int OFS_QUERY_END    = OFS_QUERY_START + TIME_W;
  localparam int S_DATA_W         = ((OFS_QUERY_END + TIME_W + 7) / 8) * 8;
  localparam int S_USER_W         = REQ_W + 1;

  // Bit offsets inside the master-side tdata.
  localparam int OFS_FOUND_INDEX = 0;
  localparam int OFS_FOUND_VALUE = OFS_FOUND_INDEX + FIDX_W;
  localparam int OFS_WINDOW_SUM  = OFS_FOUND_VALUE + VAL_W;
  localparam int M_DATA_USED     = OFS_WINDOW_SUM + SUM_W;
  localparam int M_DATA_W        = ((M_DATA_USED + 7) / 8) * 8;

  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WINDOW = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FEW     = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_BAD_TYPE,
    OP_FEW,
    OP_RD_FIRST,
    OP_RD_LAST,
    OP_PROBE,
    OP_STEP,
    OP_CLAMP,
    OP_FIX_UP,
    OP_FIX_DN,
    OP_MISS_LOOKUP,
    OP_MISS_WINDOW,
    OP_FOUND,
    OP_ACCUM,
    OP_EMIT
  } op_t;

  // Status returned by the datapath to the controller.
  typedef struct packed {
    logic is_load;
    logic is_lookup;
    logic is_window;
    logic few;
    logic t_ge_pos;
    logic t_le_pos;
    logic more;
    logic sum_go;
  } flags_t;

endpackage

// File: sv/tstq_ctrl.sv
module tstq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  tstq_pkg::flags_t flags,
  output tstq_pkg::op_t   op
);

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001,
    S_DEC  = 18'h00002,
    S_W0   = 18'h00004,
    S_C0   = 18'h00008,
    S_W1   = 18'h00010,
    S_C1   = 18'h00020,
    S_WS   = 18'h00040,
    S_CS   = 18'h00080,
    S_CL   = 18'h00100,
    S_WA   = 18'h00200,
    S_CA   = 18'h00400,
    S_WB   = 18'h00800,
    S_CB   = 18'h01000,
    S_WV   = 18'h02000,
    S_CV   = 18'h04000,
    S_SL   = 18'h08000,
    S_WL   = 18'h10000,
    S_DONE = 18'h20000
  } state_t;

  state_t state, state_next;
  logic   out_valid;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign out_free = !out_valid || m_tready;

  always_comb begin
    state_next = state;
    op         = tstq_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op         = tstq_pkg::OP_CAPTURE;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (flags.is_load) begin
          op         = tstq_pkg::OP_LOAD;
          state_next = S_DONE;
        end else if (!flags.is_lookup && !flags.is_window) begin
          op         = tstq_pkg::OP_BAD_TYPE;
          state_next = S_DONE;
        end else if (flags.few) begin
          op         = tstq_pkg::OP_FEW;
          state_next = S_DONE;
        end else begin
          op         = tstq_pkg::OP_RD_FIRST;
          state_next = S_W0;
        end
      end
      S_W0: state_next = S_C0;
      S_C0, S_C1: begin
        if ((state == S_C0) ? flags.t_ge_pos : flags.t_le_pos) begin
          if (flags.is_lookup) begin
            op         = tstq_pkg::OP_MISS_LOOKUP;
            state_next = S_DONE;
          end else begin
            op         = tstq_pkg::OP_MISS_WINDOW;
            state_next = S_WV;
          end
        end else if (state == S_C0) begin
          op         = tstq_pkg::OP_RD_LAST;
          state_next = S_W1;
        end else begin
          op         = tstq_pkg::OP_PROBE;
          state_next = S_WS;
        end
      end
      S_W1: state_next = S_C1;
      S_WS: state_next = S_CS;
      S_CS: begin
        op         = tstq_pkg::OP_STEP;
        state_next = flags.more ? S_WS : S_CL;
      end
      S_CL: begin
        op         = tstq_pkg::OP_CLAMP;
        state_next = S_WA;
      end
      S_WA: state_next = S_CA;
      S_CA: begin
        op         = tstq_pkg::OP_FIX_UP;
        state_next = S_WB;
      end
      S_WB: state_next = S_CB;
      S_CB: begin
        op         = tstq_pkg::OP_FIX_DN;
        state_next = S_WV;
      end
      S_WV: state_next = S_CV;
      S_CV: begin
        op         = tstq_pkg::OP_FOUND;
        state_next = flags.is_lookup ? S_DONE : S_SL;
      end
      S_SL: begin
        if (flags.sum_go) begin
          op         = tstq_pkg::OP_ACCUM;
          state_next = S_WL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WL: state_next = S_SL;
      S_DONE: begin
        if (out_free) begin
          op         = tstq_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == tstq_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/tstq_dp.sv
module tstq_dp #(
  parameter int TABLE_DEPTH = 1024,
  parameter int TIME_BITS   = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [tstq_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic [tstq_pkg::S_USER_W-1:0]   s_tuser,
  input  tstq_pkg::op_t                   op,
  output tstq_pkg::flags_t                flags,
  output logic [tstq_pkg::M_DATA_W-1:0]   m_tdata,
  output logic [tstq_pkg::STAT_W-1:0]     m_tuser
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = (TIME_BITS < tstq_pkg::TIME_W) ? TIME_BITS : tstq_pkg::TIME_W;
  localparam int VW = tstq_pkg::VAL_W;
  localparam int SW = tstq_pkg::SUM_W;

  logic [TW-1:0] tmem [TABLE_DEPTH];
  logic [VW-1:0] vmem [TABLE_DEPTH];

  logic [tstq_pkg::REQ_W-1:0] req_type;
  logic                       first;
  logic [TW-1:0]              s_time;
  logic [VW-1:0]              s_val;
  logic [TW-1:0]              pos;
  logic [TW-1:0]              endt;
  logic [CW-1:0]              count;
  logic [CW-1:0]              base;
  logic [CW-1:0]              len;
  logic [CW-1:0]              idx;
  logic [AW-1:0]              addr;
  logic [TW-1:0]              t_q;
  logic [VW-1:0]              v_q;

  logic [tstq_pkg::FIDX_W-1:0] res_idx;
  logic [VW-1:0]               res_val;
  logic [SW-1:0]               res_sum;
  logic [tstq_pkg::STAT_W-1:0] res_status;

  logic [CW-1:0] cnt_eff;
  logic          load_full;
  logic [CW-1:0] half;
  logic [CW-1:0] probe;
  logic [CW-1:0] nb;
  logic [CW-1:0] nl;
  logic [CW-1:0] naddr;
  logic [CW-1:0] last;
  logic [CW-1:0] nm2;
  logic [CW-1:0] clamped;
  logic [CW-1:0] idx_up;
  logic [CW-1:0] idx_dn;
  logic [CW-1:0] idx_inc;
  logic          t_ge;
  logic          t_le;

  logic signed [SW:0] sum_wide;
  logic [SW-1:0]      sum_sat;

  assign cnt_eff   = first ? '0 : count;
  assign load_full = (cnt_eff == CW'(TABLE_DEPTH));
  assign last      = count - CW'(1);
  assign nm2       = count - CW'(2);

  assign t_ge = (t_q >= pos);
  assign t_le = (t_q <= pos);

  // One halving step: the probed entry decides which half the answer lies in.
  assign half  = len >> 1;
  assign probe = base + half;
  assign nb    = t_ge ? base : probe;
  assign nl    = t_ge ? half : len - half;
  assign naddr = nb + (nl >> 1);

  assign clamped = (base < CW'(1)) ? CW'(1) : ((base > nm2) ? nm2 : base);
  assign idx_up  = ((idx < last) && !t_ge) ? idx + CW'(1) : idx;
  assign idx_dn  = ((idx != '0) && t_ge) ? idx - CW'(1) : idx;
  assign idx_inc = idx + CW'(1);

  assign sum_wide = $signed({res_sum[SW-1], res_sum})
                  + $signed({{(SW + 1 - VW){v_q[VW-1]}}, v_q});
  always_comb begin
    if (sum_wide[SW] != sum_wide[SW-1]) begin
      sum_sat = sum_wide[SW] ? tstq_pkg::SUM_MIN : tstq_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_wide[SW-1:0];
    end
  end

  assign flags.is_load   = (req_type == tstq_pkg::REQ_LOAD);
  assign flags.is_lookup = (req_type == tstq_pkg::REQ_LOOKUP);
  assign flags.is_window = (req_type == tstq_pkg::REQ_WINDOW);
  assign flags.few       = (count <= CW'(2));
  assign flags.t_ge_pos  = t_ge;
  assign flags.t_le_pos  = t_le;
  assign flags.more      = (nl > CW'(1));
  assign flags.sum_go    = (idx < count) && (t_q <= endt);

  // Table storage: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (op == tstq_pkg::OP_LOAD && !load_full) begin
      tmem[cnt_eff[AW-1:0]] <= s_time;
      vmem[cnt_eff[AW-1:0]] <= s_val;
    end
    t_q <= tmem[addr];
    v_q <= vmem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (op == tstq_pkg::OP_LOAD) begin
      count <= load_full ? cnt_eff : cnt_eff + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      tstq_pkg::OP_CAPTURE: begin
        req_type <= s_tuser[tstq_pkg::REQ_W-1:0];
        first    <= s_tuser[tstq_pkg::REQ_W];
        s_time   <= s_tdata[tstq_pkg::OFS_SAMPLE_TIME +: TW];
        s_val    <= s_tdata[tstq_pkg::OFS_SAMPLE_VALUE +: VW];
        pos      <= s_tdata[tstq_pkg::OFS_QUERY_START +: TW];
        endt     <= s_tdata[tstq_pkg::OFS_QUERY_END +: TW];
      end
      tstq_pkg::OP_LOAD: begin
        res_val <= '0;
        res_sum <= '0;
        if (load_full) begin
          res_idx    <= '1;
          res_status <= tstq_pkg::ST_FULL;
        end else begin
          res_idx    <= tstq_pkg::FIDX_W'(cnt_eff);
          res_status <= tstq_pkg::ST_OK;
        end
      end
      tstq_pkg::OP_BAD_TYPE, tstq_pkg::OP_MISS_LOOKUP: begin
        res_idx    <= '1;
        res_val    <= '0;
        res_sum    <= '0;
        res_status <= tstq_pkg::ST_OUTSIDE;
      end
      tstq_pkg::OP_FEW: begin
        res_idx    <= '0;
        res_val    <= '0;
        res_sum    <= '0;
        res_status <= tstq_pkg::ST_FEW;
      end
      tstq_pkg::OP_RD_FIRST: addr <= '0;
      tstq_pkg::OP_RD_LAST: begin
        addr <= last[AW-1:0];
        base <= '0;
        len  <= count;
      end
      tstq_pkg::OP_PROBE: addr <= probe[AW-1:0];
      tstq_pkg::OP_STEP: begin
        base <= nb;
        len  <= nl;
        addr <= naddr[AW-1:0];
      end
      tstq_pkg::OP_CLAMP: begin
        idx  <= clamped;
        addr <= clamped[AW-1:0];
      end
      tstq_pkg::OP_FIX_UP: begin
        idx  <= idx_up;
        addr <= idx_up[AW-1:0];
      end
      tstq_pkg::OP_FIX_DN: begin
        idx  <= idx_dn;
        addr <= idx_dn[AW-1:0];
      end
      tstq_pkg::OP_MISS_WINDOW: begin
        idx  <= '0;
        addr <= '0;
      end
      tstq_pkg::OP_FOUND: begin
        res_idx    <= tstq_pkg::FIDX_W'(idx);
        res_val    <= v_q;
        res_sum    <= '0;
        res_status <= tstq_pkg::ST_OK;
      end
      tstq_pkg::OP_ACCUM: begin
        res_sum <= sum_sat;
        idx     <= idx_inc;
        addr    <= idx_inc[AW-1:0];
      end
      tstq_pkg::OP_EMIT: begin
        m_tdata <= {{(tstq_pkg::M_DATA_W - tstq_pkg::M_DATA_USED){1'b0}},
                    res_sum, res_val, res_idx};
        m_tuser <= res_status;
      end
      default: ;
    endcase
  end

endmodule

// File: sv/timestamp_table_query_engine_core.sv
// Time-sorted sample table with lookup and window-sum queries. Load transfers
// append a sample (first_sample empties the table first); lookups and window
// queries run a halving search over the table memory, which has a single
// registered read port. One request is worked at a time, but a finished
// result waits in the output register so the next request can be taken
// before it is collected. Table entries need no clearing after reset: only
// entries already loaded are read.
module timestamp_table_query_engine_core #(
  parameter int TABLE_DEPTH = 1024,
  parameter int TIME_BITS   = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // sample_time[47:0], sample_value[79:48], query_start[127:80], query_end[175:128]
  input  logic [tstq_pkg::S_DATA_W-1:0] s_tdata,
  // req_type[1:0], first_sample[2]
  input  logic [tstq_pkg::S_USER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // found_index[10:0], found_value[42:11], window_sum[90:43], zero fill above
  output logic [tstq_pkg::M_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [tstq_pkg::STAT_W-1:0]   m_tuser
);

  tstq_pkg::op_t    op;
  tstq_pkg::flags_t flags;

  tstq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .flags    (flags),
    .op       (op)
  );

  tstq_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .op      (op),
    .flags   (flags),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule
